>>> src/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths and the CORDIC arctangent table for the quaternion to
// ZYX Euler angle converter.
// ----------------------------------------------------------------------------
package qte_pkg;

    // CORDIC datapath width: Q28 operands of up to 34 bits plus gain headroom
    localparam int CORDIC_W = 38;
    // operand widths after the sums of products
    localparam int SUM_W    = 34;
    // pitch argument saturated to +/- 2^28
    localparam int SARG_W   = 30;
    localparam int SMAG_W   = 29;
    // square root: radicand up to 2^56, root up to 2^28
    localparam int RAD_W    = 57;
    localparam int ROOT_W   = 29;
    localparam int ANGLE_W  = 16;
    localparam int ACC_W    = 32;
    localparam int TAB_LEN  = 24;

    localparam logic signed [SUM_W-1:0] Q28_ONE   = SUM_W'(64'sd1 <<< 28);
    localparam logic signed [ANGLE_W-1:0] PITCH_MAX = 16'sd16384;
    localparam logic signed [ANGLE_W-1:0] PITCH_MIN = -16'sd16384;

    typedef logic signed [ANGLE_W-1:0] angle_t;

    // round(atan(2^-i) * 2^31 / pi)
    function automatic logic [ACC_W-1:0] atan_entry(input int idx);
        logic [ACC_W-1:0] v;
        begin
            case (idx)
                0:       v = 32'h20000000;
                1:       v = 32'h12E4051E;
                2:       v = 32'h09FB385B;
                3:       v = 32'h051111D4;
                4:       v = 32'h028B0D43;
                5:       v = 32'h0145D7E1;
                6:       v = 32'h00A2F61E;
                7:       v = 32'h00517C55;
                8:       v = 32'h0028BE53;
                9:       v = 32'h00145F2F;
                10:      v = 32'h000A2F98;
                11:      v = 32'h000517CC;
                12:      v = 32'h00028BE6;
                13:      v = 32'h000145F3;
                14:      v = 32'h0000A2F9;
                15:      v = 32'h0000517C;
                16:      v = 32'h000028BE;
                17:      v = 32'h0000145F;
                18:      v = 32'h00000A2F;
                19:      v = 32'h00000517;
                20:      v = 32'h0000028B;
                21:      v = 32'h00000145;
                22:      v = 32'h000000A2;
                23:      v = 32'h00000051;
                default: v = 32'h00000000;
            endcase
            return v;
        end
    endfunction

endpackage

>>> src/quaternion_to_euler_zyx.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_zyx
// Converts a Q1.14 quaternion into ZYX roll, pitch and yaw binary angles.
// ----------------------------------------------------------------------------
// Fully pipelined: one request is taken every cycle unless the pipe is
// frozen. The pitch path is the longest one: products, sums, the square of
// the pitch argument, a 29-stage bit-per-cycle square root, then a CORDIC
// of CORDIC_STAGES iterations with a fold stage
// and a rounding stage, and the output register. Roll and yaw run their
// CORDICs early and wait in short delay lines. The whole pipe advances
// together; it freezes only while a finished result is held by angle_stall,
// and quat_stall is raised exactly then. Angles are 16-bit binary angles
// (32768 = pi); pitch stays within +/- 16384.
module quaternion_to_euler_zyx #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            quat_valid,
    output logic            quat_stall,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    output logic            angle_valid,
    input  logic            angle_stall,
    output qte_pkg::angle_t roll_angle,
    output qte_pkg::angle_t pitch_angle,
    output qte_pkg::angle_t yaw_angle
);
    import qte_pkg::*;

    // pitch-path wait from the sums register to the square root output
    localparam int ALIGN = ROOT_W + 1;
    localparam int LAT   = CORDIC_STAGES + ROOT_W + 6;

    logic en;
    logic [LAT-1:0] vld_reg;

    // stage A: products, exact Q28
    logic signed [31:0] p_wx_reg, p_yz_reg, p_xx_reg, p_yy_reg, p_zz_reg;
    logic signed [31:0] p_wz_reg, p_xy_reg, p_wy_reg, p_zx_reg;

    // stage B: atan2 operands and saturated pitch argument
    logic signed [SUM_W-1:0]  ry_reg, rx_reg, yy_reg, yx_reg;
    logic signed [SUM_W-1:0]  ry_next, rx_next, yy_next, yx_next, s_full;
    logic signed [SARG_W-1:0] s_reg, s_next;

    // stage C: s squared
    logic [SMAG_W-1:0]      s_mag;
    logic [2*SMAG_W-1:0]    sq_reg;
    logic [RAD_W-1:0]       radicand;
    logic [ROOT_W-1:0]      root;

    logic signed [SARG_W-1:0] s_dly_reg [0:ALIGN-1];
    angle_t roll_dly_reg [0:ALIGN-1];
    angle_t yaw_dly_reg  [0:ALIGN-1];

    angle_t roll_c, yaw_c, pitch_c;
    angle_t roll_reg, pitch_reg, yaw_reg;
    angle_t pitch_next;

    // pipe moves unless a finished result is being held
    assign en          = !vld_reg[LAT-1] || !angle_stall;
    assign quat_stall  = !en;
    assign angle_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], quat_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_wx_reg <= quat_w * quat_x;
            p_yz_reg <= quat_y * quat_z;
            p_xx_reg <= quat_x * quat_x;
            p_yy_reg <= quat_y * quat_y;
            p_zz_reg <= quat_z * quat_z;
            p_wz_reg <= quat_w * quat_z;
            p_xy_reg <= quat_x * quat_y;
            p_wy_reg <= quat_w * quat_y;
            p_zx_reg <= quat_z * quat_x;
        end
    end

    always_comb
    begin
        ry_next = (SUM_W'(p_wx_reg) + SUM_W'(p_yz_reg)) <<< 1;
        rx_next = Q28_ONE - ((SUM_W'(p_xx_reg) + SUM_W'(p_yy_reg)) <<< 1);
        yy_next = (SUM_W'(p_wz_reg) + SUM_W'(p_xy_reg)) <<< 1;
        yx_next = Q28_ONE - ((SUM_W'(p_yy_reg) + SUM_W'(p_zz_reg)) <<< 1);
        s_full  = (SUM_W'(p_wy_reg) - SUM_W'(p_zx_reg)) <<< 1;
        // clamp where asin would be undefined
        if (s_full > Q28_ONE)
        begin
            s_next = SARG_W'(Q28_ONE);
        end
        else if (s_full < -Q28_ONE)
        begin
            s_next = -SARG_W'(Q28_ONE);
        end
        else
        begin
            s_next = SARG_W'(s_full);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ry_reg <= ry_next;
            rx_reg <= rx_next;
            yy_reg <= yy_next;
            yx_reg <= yx_next;
            s_reg  <= s_next;
        end
    end

    assign s_mag = (s_reg < 0) ? SMAG_W'(-s_reg) : SMAG_W'(s_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg <= s_mag * s_mag;
        end
    end

    // 2^56 - s^2, never negative after the clamp
    assign radicand = (RAD_W'(1) << 56) - RAD_W'(sq_reg);

    qte_isqrt u_isqrt (
        .clk      (clk),
        .en       (en),
        .radicand (radicand),
        .root     (root)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_dly_reg[0]    <= s_reg;
            roll_dly_reg[0] <= roll_c;
            yaw_dly_reg[0]  <= yaw_c;
            for (int i = 1; i < ALIGN; i++)
            begin
                s_dly_reg[i]    <= s_dly_reg[i-1];
                roll_dly_reg[i] <= roll_dly_reg[i-1];
                yaw_dly_reg[i]  <= yaw_dly_reg[i-1];
            end
        end
    end

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
        .clk   (clk),
        .en    (en),
        .y_in  (CORDIC_W'(ry_reg)),
        .x_in  (CORDIC_W'(rx_reg)),
        .angle (roll_c)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
        .clk   (clk),
        .en    (en),
        .y_in  (CORDIC_W'(yy_reg)),
        .x_in  (CORDIC_W'(yx_reg)),
        .angle (yaw_c)
    );

    // asin(s) = atan2(s, sqrt(1 - s^2))
    qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
        .clk   (clk),
        .en    (en),
        .y_in  (CORDIC_W'(s_dly_reg[ALIGN-1])),
        .x_in  (CORDIC_W'({1'b0, root})),
        .angle (pitch_c)
    );

    always_comb
    begin
        if (pitch_c > PITCH_MAX)
        begin
            pitch_next = PITCH_MAX;
        end
        else if (pitch_c < PITCH_MIN)
        begin
            pitch_next = PITCH_MIN;
        end
        else
        begin
            pitch_next = pitch_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_reg  <= roll_dly_reg[ALIGN-1];
            pitch_reg <= pitch_next;
            yaw_reg   <= yaw_dly_reg[ALIGN-1];
        end
    end

    assign roll_angle  = roll_reg;
    assign pitch_angle = pitch_reg;
    assign yaw_angle   = yaw_reg;

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        angle_valid |-> (pitch_angle <= PITCH_MAX) && (pitch_angle >= PITCH_MIN))
        else $error("pitch outside +/- half pi");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while result held");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        quat_stall |-> angle_valid && angle_stall)
        else $error("request stalled without a held result");

endmodule

>>> src/qte_isqrt.sv
// ----------------------------------------------------------------------------
// qte_isqrt
// Pipelined floor square root, one root bit per stage.
// ----------------------------------------------------------------------------
module qte_isqrt (
    input  logic                          clk,
    input  logic                          en,
    input  logic [qte_pkg::RAD_W-1:0]     radicand,
    output logic [qte_pkg::ROOT_W-1:0]    root
);
    import qte_pkg::*;

    logic [RAD_W-1:0]  rem_reg  [0:ROOT_W-1];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W-1];

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++)
        begin : g_bit
            localparam int B = ROOT_W - 1 - k;
            logic [RAD_W-1:0]  rem_cur;
            logic [ROOT_W-1:0] root_cur;
            logic [RAD_W:0]    d;

            if (k == 0)
            begin : g_first
                assign rem_cur  = radicand;
                assign root_cur = '0;
            end
            else
            begin : g_rest
                assign rem_cur  = rem_reg[k-1];
                assign root_cur = root_reg[k-1];
            end

            // (root + 2^B)^2 - root^2
            assign d = ((RAD_W+1)'(root_cur) << (B + 1)) + ((RAD_W+1)'(1) << (2 * B));

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if ({1'b0, rem_cur} >= d)
                    begin
                        rem_reg[k]  <= RAD_W'({1'b0, rem_cur} - d);
                        root_reg[k] <= root_cur | (ROOT_W'(1) << B);
                    end
                    else
                    begin
                        rem_reg[k]  <= rem_cur;
                        root_reg[k] <= root_cur;
                    end
                end
            end
        end
    endgenerate

    assign root = root_reg[ROOT_W-1];

endmodule

>>> src/qte_cordic.sv
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring CORDIC: atan2(y, x) as a 16-bit binary angle.
// ----------------------------------------------------------------------------
module qte_cordic #(
    parameter int STAGES = 16
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [qte_pkg::CORDIC_W-1:0]   y_in,
    input  logic signed [qte_pkg::CORDIC_W-1:0]   x_in,
    output qte_pkg::angle_t                       angle
);
    import qte_pkg::*;

    logic signed [CORDIC_W-1:0] x_reg    [0:STAGES];
    logic signed [CORDIC_W-1:0] y_reg    [0:STAGES];
    logic        [ACC_W-1:0]    acc_reg  [0:STAGES];
    logic                       zero_reg [0:STAGES];
    angle_t                     angle_reg;
    logic        [ACC_W-1:0]    rnd;

    // quadrant fold: left half plane rotated by +/- pi/2
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in < 0)
            begin
                if (y_in >= 0)
                begin
                    x_reg[0]   <= y_in;
                    y_reg[0]   <= -x_in;
                    acc_reg[0] <= 32'h40000000;
                end
                else
                begin
                    x_reg[0]   <= -y_in;
                    y_reg[0]   <= x_in;
                    acc_reg[0] <= 32'hC0000000;
                end
            end
            else
            begin
                x_reg[0]   <= x_in;
                y_reg[0]   <= y_in;
                acc_reg[0] <= '0;
            end
        end
    end

    genvar i;
    generate
        for (i = 0; i < STAGES; i++)
        begin : g_iter
            logic signed [CORDIC_W-1:0] dx;
            logic signed [CORDIC_W-1:0] dy;
            assign dx = y_reg[i] >>> i;
            assign dy = x_reg[i] >>> i;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    zero_reg[i+1] <= zero_reg[i];
                    if (y_reg[i] > 0)
                    begin
                        x_reg[i+1]   <= x_reg[i] + dx;
                        y_reg[i+1]   <= y_reg[i] - dy;
                        acc_reg[i+1] <= acc_reg[i] + atan_entry(i);
                    end
                    else
                    begin
                        x_reg[i+1]   <= x_reg[i] - dx;
                        y_reg[i+1]   <= y_reg[i] + dy;
                        acc_reg[i+1] <= acc_reg[i] - atan_entry(i);
                    end
                end
            end
        end
    endgenerate

    // round half up to 16 bits, wrapping
    assign rnd = acc_reg[STAGES] + 32'h00008000;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= zero_reg[STAGES] ? '0 : angle_t'(rnd[ACC_W-1:ACC_W-ANGLE_W]);
        end
    end

    assign angle = angle_reg;

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks quaternion_to_euler_zyx against a built-in predictor of the
// fixed-point roll, pitch and yaw CORDIC arithmetic, under random idling.
// ----------------------------------------------------------------------------
module testbench;

    import qte_pkg::*;

    localparam int STAGES    = 16;
    localparam int LATENCY   = STAGES + 35;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 1300;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } quat_t;

    typedef struct packed {
        angle_t roll;
        angle_t pitch;
        angle_t yaw;
    } euler_t;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   quat_valid = 1'b0;
    logic   quat_stall;
    logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
    logic   angle_valid;
    logic   angle_stall = 1'b0;
    angle_t roll_angle, pitch_angle, yaw_angle;

    quat_t  pending_quats[$];
    euler_t expected_angles[$];
    bit     stim_done = 1'b0;
    int     fail_count = 0;
    int     idle_cycles = 0;
    bit     hold_off_req = 1'b0;

    quaternion_to_euler_zyx #(.CORDIC_STAGES(STAGES)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .quat_valid(quat_valid), .quat_stall(quat_stall),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .angle_valid(angle_valid), .angle_stall(angle_stall),
        .roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // arithmetic shift right of a 64-bit value (floor rounding)
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    // vectoring CORDIC: atan2(y, x) as a 32-bit binary angle
    function automatic logic [31:0] vector_angle(longint y, longint x);
        logic [31:0] acc;
        longint      t, dx, dy;
        acc = '0;
        if (x == 0 && y == 0)
            return '0;
        // left half plane: fold by a quarter turn first
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;  y = -t;  acc = 32'h40000000;
            end
            else
            begin
                x = -y; y = t;   acc = 32'hC0000000;
            end
        end
        for (int i = 0; i < STAGES && i < TAB_LEN; i++)
        begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (y > 0)
            begin
                x += dx; y -= dy; acc += atan_entry(i);
            end
            else
            begin
                x -= dx; y += dy; acc -= atan_entry(i);
            end
        end
        return acc;
    endfunction

    // floor square root, bit by bit
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // 32-bit accumulator to 16-bit angle, round half up with wrap
    function automatic angle_t round_angle(logic [31:0] acc);
        logic [31:0] r;
        r = acc + 32'h8000;
        return angle_t'(r[31:16]);
    endfunction

    function automatic euler_t predict_euler(quat_t q);
        longint w, x, y, z, ry, rx, yy, yx, s, p;
        longint unsigned c;
        euler_t e;
        w = q.w; x = q.x; y = q.y; z = q.z;
        ry = 2 * (w * x + y * z);
        rx = (64'sd1 <<< 28) - 2 * (x * x + y * y);
        yy = 2 * (w * z + x * y);
        yx = (64'sd1 <<< 28) - 2 * (y * y + z * z);
        s  = 2 * (w * y - z * x);
        // pitch argument saturates at +/- 1.0
        if (s > (64'sd1 <<< 28))
            s = 64'sd1 <<< 28;
        if (s < -(64'sd1 <<< 28))
            s = -(64'sd1 <<< 28);
        c = floor_sqrt((64'd1 << 56) - longint'(s * s));
        p = round_angle(vector_angle(s, longint'(c)));
        if (p > 16384)
            p = 16384;
        if (p < -16384)
            p = -16384;
        e.roll  = round_angle(vector_angle(ry, rx));
        e.pitch = angle_t'(p);
        e.yaw   = round_angle(vector_angle(yy, yx));
        return e;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic quat_t quat_of(int w, int x, int y, int z);
        quat_t q;
        q.w = 16'(w); q.x = 16'(x); q.y = 16'(y); q.z = 16'(z);
        return q;
    endfunction

    // random unit-ish quaternion: mostly normalized, some raw noise
    function automatic quat_t random_quat();
        quat_t q;
        real   a, b, c, d, n;
        int    kind;
        kind = $urandom_range(0, 9);
        if (kind < 7)
        begin
            a = $itor($signed($urandom_range(0, 65534)) - 32767);
            b = $itor($signed($urandom_range(0, 65534)) - 32767);
            c = $itor($signed($urandom_range(0, 65534)) - 32767);
            d = $itor($signed($urandom_range(0, 65534)) - 32767);
            n = $sqrt(a * a + b * b + c * c + d * d);
            if (n < 1.0)
                n = 1.0;
            q = quat_of($rtoi(a * 16384.0 / n), $rtoi(b * 16384.0 / n),
                        $rtoi(c * 16384.0 / n), $rtoi(d * 16384.0 / n));
        end
        else if (kind < 9)
            q = quat_of($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                        $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384);
        else
            q = {$urandom(), $urandom()};
        return q;
    endfunction

    initial
    begin
        // identity, axes, gimbal lock both ways, pi wrap, zero vector, extremes
        pending_quats.push_back(quat_of(16384, 0, 0, 0));
        pending_quats.push_back(quat_of(-16384, 0, 0, 0));
        pending_quats.push_back(quat_of(0, 16384, 0, 0));
        pending_quats.push_back(quat_of(0, 0, 16384, 0));
        pending_quats.push_back(quat_of(0, 0, 0, 16384));
        pending_quats.push_back(quat_of(0, 0, 0, -16384));
        pending_quats.push_back(quat_of(11585, 0, 11585, 0));
        pending_quats.push_back(quat_of(11585, 0, -11585, 0));
        pending_quats.push_back(quat_of(8192, 8192, 8192, 8192));
        pending_quats.push_back(quat_of(8192, -8192, 8192, -8192));
        pending_quats.push_back(quat_of(16384, 0, 16384, 0));     // pitch saturates high
        pending_quats.push_back(quat_of(16384, 0, -16384, 0));    // pitch saturates low
        pending_quats.push_back(quat_of(0, 11585, 11585, 0));
        pending_quats.push_back(quat_of(0, 0, 0, 0));
        pending_quats.push_back(quat_of(-32768, -32768, -32768, -32768));
        pending_quats.push_back(quat_of(32767, 32767, 32767, 32767));
        pending_quats.push_back(quat_of(32767, -32768, 32767, -32768));
        pending_quats.push_back(quat_of(-32768, 32767, -32768, 32767));
        pending_quats.push_back(quat_of(11585, -11585, 0, 0));
        pending_quats.push_back(quat_of(-11585, 0, 0, 11585));
        pending_quats.push_back(quat_of(1, -1, 1, -1));
        for (int i = 0; i < N_RANDOM; i++)
            pending_quats.push_back(random_quat());
    end

    // reset once, then a single long receiver hold-off mid-run
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (pending_quats.size() < N_RANDOM / 2);
        hold_off_req = 1'b1;
    end

    // ------------------------------------------------------------------
    // Driver: bursts and gaps, changes on the falling edge
    // ------------------------------------------------------------------
    int  burst_left = 0;
    int  gap_left = 0;
    quat_t cur_quat;

    // stall as seen at the last rising edge (i.e. request not taken)
    logic quat_stall_seen = 1'b0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            // hold the payload while a request is waiting on stall
            if (!(quat_valid && quat_stall_seen))
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    quat_valid <= 1'b0;
                end
                else if (pending_quats.size() > 0)
                begin
                    cur_quat = pending_quats.pop_front();
                    quat_w <= cur_quat.w;
                    quat_x <= cur_quat.x;
                    quat_y <= cur_quat.y;
                    quat_z <= cur_quat.z;
                    quat_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left <= burst_left - 1;
                    else
                    begin
                        burst_left <= $urandom_range(0, 40);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    quat_valid <= 1'b0;
                    stim_done <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall pattern, with one long hold-off
    // ------------------------------------------------------------------
    int  stall_mode = 0;
    int  mode_left = 0;
    int  hold_count = 0;
    bit  hold_done = 1'b0;

    always @(negedge clk)
    begin
        if (hold_off_req && !hold_done)
        begin
            angle_stall <= 1'b1;
            hold_count <= hold_count + 1;
            if (hold_count >= 3 * LATENCY)
                hold_done <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                mode_left <= $urandom_range(5, 60);
            end
            else
                mode_left <= mode_left - 1;
            case (stall_mode)
                0:       angle_stall <= 1'b0;
                1:       angle_stall <= ($urandom_range(0, 3) == 0);
                2:       angle_stall <= ($urandom_range(0, 1) == 0);
                default: angle_stall <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on input accept, compare on output accept
    // ------------------------------------------------------------------
    euler_t exp_e;

    always @(posedge clk)
    begin
        quat_stall_seen <= quat_stall;
        if (rst_n)
        begin
            if ((quat_valid && !quat_stall) || (angle_valid && !angle_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (quat_valid && !quat_stall)
            begin
                expected_angles.push_back(predict_euler({quat_w, quat_x, quat_y, quat_z}));
            end
            if (angle_valid && !angle_stall)
            begin
                if (expected_angles.size() == 0)
                begin
                    $display("%0t: unexpected result roll=%0d pitch=%0d yaw=%0d",
                             $time, roll_angle, pitch_angle, yaw_angle);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    exp_e = expected_angles.pop_front();
                    if (roll_angle !== exp_e.roll)
                    begin
                        $display("%0t: roll expected %0d actual %0d",
                                 $time, exp_e.roll, roll_angle);
                        fail_count = fail_count + 1;
                    end
                    if (pitch_angle !== exp_e.pitch)
                    begin
                        $display("%0t: pitch expected %0d actual %0d",
                                 $time, exp_e.pitch, pitch_angle);
                        fail_count = fail_count + 1;
                    end
                    if (yaw_angle !== exp_e.yaw)
                    begin
                        $display("%0t: yaw expected %0d actual %0d",
                                 $time, exp_e.yaw, yaw_angle);
                        fail_count = fail_count + 1;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // End of run and watchdog
    // ------------------------------------------------------------------
    initial
    begin
        wait (stim_done && !quat_valid && expected_angles.size() == 0);
        repeat (2 * LATENCY) @(posedge clk);
        if (fail_count == 0 && expected_angles.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        wait (idle_cycles >= WDOG_MAX);
        $display("%0t: watchdog expired", $time);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
